>>> rtl/ree_pkg.sv
package ree_pkg;

   localparam int MAX_ELLIPSOIDS  = 64;
   localparam int FRAC_BITS       = 16;
   localparam int WORDS_PER_ENTRY = 9;
   localparam int STORE_DEPTH     = MAX_ELLIPSOIDS * WORDS_PER_ENTRY;
   localparam int ADDR_W          = $clog2(STORE_DEPTH);
   localparam int ENTRY_W         = 6;
   localparam int COUNT_W         = 7;
   localparam int WORD_W          = 4;
   localparam int CFG_W           = 31;
   localparam int ACC_W           = 50;
   localparam int OP_W            = 6;
   localparam int DIV_STEPS       = 32;
   localparam int REM_W           = ACC_W + FRAC_BITS;
   localparam int DSH_W           = ACC_W + DIV_STEPS - 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX       = COUNT_W'(MAX_ELLIPSOIDS);
   localparam logic [WORD_W-1:0]  WORD_COUNT      = WORD_W'(WORDS_PER_ENTRY);
   localparam logic [CFG_W-1:0]   MAX_MAHAL_RESET = 31'd229376;
   localparam logic [CFG_W-1:0]   MIN_RANGE_RESET = 31'd0;
   localparam logic [CFG_W-1:0]   MAX_RANGE_RESET = 31'd7864320;
   localparam logic [COUNT_W-1:0] COUNT_RESET     = 7'd0;

   localparam logic [OP_W-1:0] OP_THR        = 6'd0;
   localparam logic [OP_W-1:0] OP_MAC1_FIRST = 6'd1;
   localparam logic [OP_W-1:0] OP_MAC1_LAST  = 6'd24;
   localparam logic [OP_W-1:0] OP_MAC2_FIRST = 6'd25;
   localparam logic [OP_W-1:0] OP_MAC2_LAST  = 6'd39;

   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_RAY  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      CSR_MAX_MAHAL,
      CSR_MIN_RANGE,
      CSR_MAX_RANGE,
      CSR_COUNT
   } csr_index_type;

   typedef enum logic [3:0] {
      OA_A00, OA_A01, OA_A02, OA_A11, OA_A12, OA_A22,
      OA_DX, OA_DY, OA_DZ, OA_EX, OA_EY, OA_EZ, OA_T, OA_MM
   } a_sel_type;

   typedef enum logic [4:0] {
      OB_VX, OB_VY, OB_VZ, OB_DX, OB_DY, OB_DZ,
      OB_AVX, OB_AVY, OB_AVZ, OB_ADX, OB_ADY, OB_ADZ,
      OB_EX, OB_EY, OB_EZ, OB_AEX, OB_AEY, OB_AEZ, OB_MM
   } b_sel_type;

   typedef enum logic [3:0] {
      D_AVX, D_AVY, D_AVZ, D_ADX, D_ADY, D_ADZ,
      D_EX, D_EY, D_EZ, D_AEX, D_AEY, D_AEZ,
      D_NUM, D_DEN, D_M2, D_THR
   } dest_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      first;
      logic      last;
      dest_type  dest;
   } mac_op_type;

   typedef struct packed {
      logic               capture_ray;
      logic               load_en;
      logic               fetch_rd;
      logic [WORD_W-1:0]  fetch_word;
      logic [ENTRY_W-1:0] entry;
      logic               vsub;
      logic               issue;
      logic [OP_W-1:0]    op_idx;
      logic               div_init;
      logic               div_step;
      logic               div_end;
      logic               result_load;
      logic               last;
   } dp_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count_n;
   } dp_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      logic signed [31:0]      r;
      hi = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
      lo = {{(ACC_W-32){1'b1}}, 32'h80000000};
      if (x > hi) begin
         r = 32'sh7fffffff;
      end else if (x < lo) begin
         r = 32'h80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic mac_op_type mac_op(input logic [OP_W-1:0] idx);
      mac_op_type op;
      case (idx)
         6'd0:  op = '{OA_MM,  OB_MM,  1'b1, 1'b1, D_THR};
         6'd1:  op = '{OA_A00, OB_VX,  1'b1, 1'b0, D_AVX};
         6'd2:  op = '{OA_A01, OB_VY,  1'b0, 1'b0, D_AVX};
         6'd3:  op = '{OA_A02, OB_VZ,  1'b0, 1'b1, D_AVX};
         6'd4:  op = '{OA_A01, OB_VX,  1'b1, 1'b0, D_AVY};
         6'd5:  op = '{OA_A11, OB_VY,  1'b0, 1'b0, D_AVY};
         6'd6:  op = '{OA_A12, OB_VZ,  1'b0, 1'b1, D_AVY};
         6'd7:  op = '{OA_A02, OB_VX,  1'b1, 1'b0, D_AVZ};
         6'd8:  op = '{OA_A12, OB_VY,  1'b0, 1'b0, D_AVZ};
         6'd9:  op = '{OA_A22, OB_VZ,  1'b0, 1'b1, D_AVZ};
         6'd10: op = '{OA_A00, OB_DX,  1'b1, 1'b0, D_ADX};
         6'd11: op = '{OA_A01, OB_DY,  1'b0, 1'b0, D_ADX};
         6'd12: op = '{OA_A02, OB_DZ,  1'b0, 1'b1, D_ADX};
         6'd13: op = '{OA_A01, OB_DX,  1'b1, 1'b0, D_ADY};
         6'd14: op = '{OA_A11, OB_DY,  1'b0, 1'b0, D_ADY};
         6'd15: op = '{OA_A12, OB_DZ,  1'b0, 1'b1, D_ADY};
         6'd16: op = '{OA_A02, OB_DX,  1'b1, 1'b0, D_ADZ};
         6'd17: op = '{OA_A12, OB_DY,  1'b0, 1'b0, D_ADZ};
         6'd18: op = '{OA_A22, OB_DZ,  1'b0, 1'b1, D_ADZ};
         6'd19: op = '{OA_DX,  OB_AVX, 1'b1, 1'b0, D_NUM};
         6'd20: op = '{OA_DY,  OB_AVY, 1'b0, 1'b0, D_NUM};
         6'd21: op = '{OA_DZ,  OB_AVZ, 1'b0, 1'b1, D_NUM};
         6'd22: op = '{OA_DX,  OB_ADX, 1'b1, 1'b0, D_DEN};
         6'd23: op = '{OA_DY,  OB_ADY, 1'b0, 1'b0, D_DEN};
         6'd24: op = '{OA_DZ,  OB_ADZ, 1'b0, 1'b1, D_DEN};
         6'd25: op = '{OA_T,   OB_DX,  1'b1, 1'b1, D_EX};
         6'd26: op = '{OA_T,   OB_DY,  1'b1, 1'b1, D_EY};
         6'd27: op = '{OA_T,   OB_DZ,  1'b1, 1'b1, D_EZ};
         6'd28: op = '{OA_A00, OB_EX,  1'b1, 1'b0, D_AEX};
         6'd29: op = '{OA_A01, OB_EY,  1'b0, 1'b0, D_AEX};
         6'd30: op = '{OA_A02, OB_EZ,  1'b0, 1'b1, D_AEX};
         6'd31: op = '{OA_A01, OB_EX,  1'b1, 1'b0, D_AEY};
         6'd32: op = '{OA_A11, OB_EY,  1'b0, 1'b0, D_AEY};
         6'd33: op = '{OA_A12, OB_EZ,  1'b0, 1'b1, D_AEY};
         6'd34: op = '{OA_A02, OB_EX,  1'b1, 1'b0, D_AEZ};
         6'd35: op = '{OA_A12, OB_EY,  1'b0, 1'b0, D_AEZ};
         6'd36: op = '{OA_A22, OB_EZ,  1'b0, 1'b1, D_AEZ};
         6'd37: op = '{OA_EX,  OB_AEX, 1'b1, 1'b0, D_M2};
         6'd38: op = '{OA_EY,  OB_AEY, 1'b0, 1'b0, D_M2};
         6'd39: op = '{OA_EZ,  OB_AEZ, 1'b0, 1'b1, D_M2};
         default: op = '{OA_MM, OB_MM, 1'b1, 1'b0, D_THR};
      endcase
      return op;
   endfunction

endpackage

>>> rtl/ree_ctrl.sv
module ree_ctrl import ree_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [0:0]    req_command,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_THR     = 12'b000000000010,
      S_FETCH   = 12'b000000000100,
      S_VSUB    = 12'b000000001000,
      S_MAC1    = 12'b000000010000,
      S_DRAIN1  = 12'b000000100000,
      S_DIVINIT = 12'b000001000000,
      S_DIV     = 12'b000010000000,
      S_DIVEND  = 12'b000100000000,
      S_MAC2    = 12'b001000000000,
      S_DRAIN2  = 12'b010000000000,
      S_RESULT  = 12'b100000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [OP_W-1:0]    cnt_ff, cnt_in;
   logic [COUNT_W-1:0] entry_ff, entry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               is_ray;
   logic               last_entry;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign accept     = req_valid && req_ready;
   assign is_ray     = (command_type'(req_command) == CMD_RAY);
   assign last_entry = (COUNT_W'(entry_ff + 1'b1) == status.count_n);

   always_comb begin
      cmd             = '0;
      cmd.capture_ray = accept && is_ray;
      cmd.load_en     = accept && !is_ray;
      cmd.fetch_rd    = (state_ff == S_FETCH) && (cnt_ff[WORD_W-1:0] < WORD_COUNT);
      cmd.fetch_word  = cnt_ff[WORD_W-1:0];
      cmd.entry       = entry_ff[ENTRY_W-1:0];
      cmd.vsub        = (state_ff == S_VSUB);
      cmd.issue       = (state_ff == S_THR) || (state_ff == S_MAC1) || (state_ff == S_MAC2);
      cmd.op_idx      = (state_ff == S_THR) ? OP_THR : cnt_ff;
      cmd.div_init    = (state_ff == S_DIVINIT);
      cmd.div_step    = (state_ff == S_DIV);
      cmd.div_end     = (state_ff == S_DIVEND);
      cmd.result_load = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_ready);
      cmd.last        = last_entry;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      entry_in = entry_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && is_ray && (status.count_n != '0)) begin
               state_in = S_THR;
               entry_in = '0;
            end
         end
         S_THR: begin
            state_in = S_FETCH;
            cnt_in   = '0;
         end
         S_FETCH: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == OP_W'(WORDS_PER_ENTRY)) begin
               state_in = S_VSUB;
            end
         end
         S_VSUB: begin
            state_in = S_MAC1;
            cnt_in   = OP_MAC1_FIRST;
         end
         S_MAC1: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == OP_MAC1_LAST) begin
               state_in = S_DRAIN1;
            end
         end
         S_DRAIN1: begin
            state_in = S_DIVINIT;
         end
         S_DIVINIT: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == OP_W'(DIV_STEPS - 1)) begin
               state_in = S_DIVEND;
            end
         end
         S_DIVEND: begin
            state_in = S_MAC2;
            cnt_in   = OP_MAC2_FIRST;
         end
         S_MAC2: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == OP_MAC2_LAST) begin
               state_in = S_DRAIN2;
            end
         end
         S_DRAIN2: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (cmd.result_load) begin
               if (last_entry) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_FETCH;
                  cnt_in   = '0;
                  entry_in = entry_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         entry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         entry_ff     <= entry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/ree_dpath.sv
module ree_dpath import ree_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [ENTRY_W-1:0]  req_entry_index,
   input  logic [WORD_W-1:0]   req_word_select,
   input  logic signed [31:0]  req_word_value,
   input  logic signed [31:0]  req_origin_x,
   input  logic signed [31:0]  req_origin_y,
   input  logic signed [31:0]  req_origin_z,
   input  logic signed [31:0]  req_dir_x,
   input  logic signed [31:0]  req_dir_y,
   input  logic signed [31:0]  req_dir_z,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_write_data,
   output logic [ENTRY_W-1:0]  rsp_ellipsoid_index,
   output logic                rsp_hit,
   output logic signed [31:0]  rsp_range_along_ray,
   output logic                rsp_last
);

   logic [CFG_W-1:0]   mm_ff, min_ff, max_ff;
   logic [COUNT_W-1:0] count_ff;

   logic [31:0]        store_mem [STORE_DEPTH];
   logic [ADDR_W-1:0]  load_addr, fetch_addr;
   logic [31:0]        rd_ff;
   logic               cap_v_ff;
   logic [WORD_W-1:0]  cap_sel_ff;

   logic signed [31:0] w_ff  [WORDS_PER_ENTRY];
   logic signed [31:0] o_ff  [3];
   logic signed [31:0] d_ff  [3];
   logic signed [31:0] v_ff  [3];
   logic signed [32:0] om_ff [3];
   logic signed [32:0] mo    [3];
   logic signed [32:0] omd   [3];
   logic signed [31:0] av_ff [3];
   logic signed [31:0] ad_ff [3];
   logic signed [31:0] ev_ff [3];
   logic signed [31:0] ae_ff [3];
   logic signed [31:0] t_ff, t_in;
   logic signed [ACC_W-1:0] num_ff, den_ff, m2_ff, thr_ff;

   mac_op_type         cur_op, op_ff;
   logic               opv_ff;
   logic signed [31:0] opa, opb;
   logic signed [63:0] prod_ff, prod_in, prod_sh;
   logic signed [ACC_W-1:0] acc_ff, acc_in, bias, shifted;
   logic signed [31:0] acc_sat;

   logic [ACC_W-1:0]   num_abs, den_abs;
   logic [REM_W-1:0]   rem_ff;
   logic [DSH_W-1:0]   dsh_ff;
   logic [DIV_STEPS-1:0] q_ff;
   logic               neg_ff;
   logic               div_ge;
   logic [31:0]        t_mag;

   logic               den_zero, m2_ok, min_ok, max_ok;

   assign status.count_n = (count_ff > COUNT_MAX) ? COUNT_MAX : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_ff    <= MAX_MAHAL_RESET;
         min_ff   <= MIN_RANGE_RESET;
         max_ff   <= MAX_RANGE_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_MAHAL: mm_ff    <= csr_write_data;
            CSR_MIN_RANGE: min_ff   <= csr_write_data;
            CSR_MAX_RANGE: max_ff   <= csr_write_data;
            CSR_COUNT:     count_ff <= csr_write_data[COUNT_W-1:0];
            default:       count_ff <= count_ff;
         endcase
      end
   end

   assign load_addr  = ADDR_W'(req_entry_index) * ADDR_W'(WORDS_PER_ENTRY)
                     + ADDR_W'(req_word_select);
   assign fetch_addr = ADDR_W'(cmd.entry) * ADDR_W'(WORDS_PER_ENTRY) + ADDR_W'(cmd.fetch_word);

   always_ff @(posedge clock) begin
      if (cmd.load_en && (req_word_select < WORD_COUNT)
          && ({1'b0, req_entry_index} < COUNT_MAX)) begin
         store_mem[load_addr] <= req_word_value;
      end
      if (cmd.fetch_rd) begin
         rd_ff <= store_mem[fetch_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_v_ff <= 1'b0;
      end else begin
         cap_v_ff <= cmd.fetch_rd;
      end
      cap_sel_ff <= cmd.fetch_word;
      if (cap_v_ff) begin
         w_ff[cap_sel_ff] <= rd_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mo[i]  = {w_ff[i][31], w_ff[i]} - {o_ff[i][31], o_ff[i]};
         omd[i] = {o_ff[i][31], o_ff[i]} - {w_ff[i][31], w_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_ray) begin
         o_ff[0] <= req_origin_x;
         o_ff[1] <= req_origin_y;
         o_ff[2] <= req_origin_z;
         d_ff[0] <= req_dir_x;
         d_ff[1] <= req_dir_y;
         d_ff[2] <= req_dir_z;
      end
      if (cmd.vsub) begin
         for (int i = 0; i < 3; i++) begin
            v_ff[i]  <= sat32(ACC_W'(mo[i]));
            om_ff[i] <= omd[i];
         end
      end
   end

   assign cur_op = mac_op(cmd.op_idx);

   always_comb begin
      case (cur_op.a_sel)
         OA_A00:  opa = w_ff[3];
         OA_A01:  opa = w_ff[4];
         OA_A02:  opa = w_ff[5];
         OA_A11:  opa = w_ff[6];
         OA_A12:  opa = w_ff[7];
         OA_A22:  opa = w_ff[8];
         OA_DX:   opa = d_ff[0];
         OA_DY:   opa = d_ff[1];
         OA_DZ:   opa = d_ff[2];
         OA_EX:   opa = ev_ff[0];
         OA_EY:   opa = ev_ff[1];
         OA_EZ:   opa = ev_ff[2];
         OA_T:    opa = t_ff;
         OA_MM:   opa = {1'b0, mm_ff};
         default: opa = '0;
      endcase
      case (cur_op.b_sel)
         OB_VX:   opb = v_ff[0];
         OB_VY:   opb = v_ff[1];
         OB_VZ:   opb = v_ff[2];
         OB_DX:   opb = d_ff[0];
         OB_DY:   opb = d_ff[1];
         OB_DZ:   opb = d_ff[2];
         OB_AVX:  opb = av_ff[0];
         OB_AVY:  opb = av_ff[1];
         OB_AVZ:  opb = av_ff[2];
         OB_ADX:  opb = ad_ff[0];
         OB_ADY:  opb = ad_ff[1];
         OB_ADZ:  opb = ad_ff[2];
         OB_EX:   opb = ev_ff[0];
         OB_EY:   opb = ev_ff[1];
         OB_EZ:   opb = ev_ff[2];
         OB_AEX:  opb = ae_ff[0];
         OB_AEY:  opb = ae_ff[1];
         OB_AEZ:  opb = ae_ff[2];
         OB_MM:   opb = {1'b0, mm_ff};
         default: opb = '0;
      endcase
   end

   assign prod_in = opa * opb;

   always_comb begin
      prod_sh = prod_ff >>> FRAC_BITS;
      shifted = prod_sh[ACC_W-1:0];
      case (op_ff.dest)
         D_EX:    bias = ACC_W'(om_ff[0]);
         D_EY:    bias = ACC_W'(om_ff[1]);
         D_EZ:    bias = ACC_W'(om_ff[2]);
         default: bias = '0;
      endcase
      acc_in  = (op_ff.first ? bias : acc_ff) + shifted;
      acc_sat = sat32(acc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opv_ff <= 1'b0;
      end else begin
         opv_ff <= cmd.issue;
      end
      if (cmd.issue) begin
         prod_ff <= prod_in;
         op_ff   <= cur_op;
      end
      if (opv_ff) begin
         acc_ff <= acc_in;
         if (op_ff.last) begin
            case (op_ff.dest)
               D_AVX:   av_ff[0] <= acc_sat;
               D_AVY:   av_ff[1] <= acc_sat;
               D_AVZ:   av_ff[2] <= acc_sat;
               D_ADX:   ad_ff[0] <= acc_sat;
               D_ADY:   ad_ff[1] <= acc_sat;
               D_ADZ:   ad_ff[2] <= acc_sat;
               D_EX:    ev_ff[0] <= acc_sat;
               D_EY:    ev_ff[1] <= acc_sat;
               D_EZ:    ev_ff[2] <= acc_sat;
               D_AEX:   ae_ff[0] <= acc_sat;
               D_AEY:   ae_ff[1] <= acc_sat;
               D_AEZ:   ae_ff[2] <= acc_sat;
               D_NUM:   num_ff   <= acc_in;
               D_DEN:   den_ff   <= acc_in;
               D_M2:    m2_ff    <= acc_in;
               D_THR:   thr_ff   <= acc_in;
               default: thr_ff   <= thr_ff;
            endcase
         end
      end
   end

   assign num_abs = num_ff[ACC_W-1] ? ACC_W'(-num_ff) : ACC_W'(num_ff);
   assign den_abs = den_ff[ACC_W-1] ? ACC_W'(-den_ff) : ACC_W'(den_ff);
   assign div_ge  = (DSH_W'(rem_ff) >= dsh_ff);
   assign t_mag   = {1'b0, q_ff[DIV_STEPS-2:0]};

   always_comb begin
      if (q_ff[DIV_STEPS-1]) begin
         t_in = neg_ff ? 32'h80000000 : 32'sh7fffffff;
      end else begin
         t_in = neg_ff ? -t_mag : t_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= {num_abs, {FRAC_BITS{1'b0}}};
         dsh_ff <= {den_abs, {(DIV_STEPS-1){1'b0}}};
         q_ff   <= '0;
         neg_ff <= num_ff[ACC_W-1] ^ den_ff[ACC_W-1];
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= rem_ff - dsh_ff[REM_W-1:0];
         end
         q_ff   <= {q_ff[DIV_STEPS-2:0], div_ge};
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.div_end) begin
         t_ff <= t_in;
      end
   end

   assign den_zero = (den_ff == '0);
   assign m2_ok    = (m2_ff <= thr_ff);
   assign min_ok   = ($signed({t_ff[31], t_ff}) >= $signed({2'b00, min_ff}));
   assign max_ok   = ($signed({t_ff[31], t_ff}) <= $signed({2'b00, max_ff}));

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_ellipsoid_index <= cmd.entry;
         rsp_hit             <= !den_zero && m2_ok && min_ok && max_ok;
         rsp_range_along_ray <= den_zero ? 32'sd0 : t_ff;
         rsp_last            <= cmd.last;
      end
   end

endmodule

>>> rtl/ray_ellipsoid_intersection.sv
// Load request: no result. Ray request: one result per table entry in use.
// Each result is computed in turn by the shared multiply-accumulate unit (39 products)
// and the 32-step divider.
// Up to 64 entries per ray; a new request is taken once the ray's last result is registered.
// Reset is synchronous: clears control and loads configuration defaults.
// The ellipsoid table is not cleared and must be loaded before use.
module ray_ellipsoid_intersection import ree_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [0:0]          req_command,
   input  logic [ENTRY_W-1:0]  req_entry_index,
   input  logic [WORD_W-1:0]   req_word_select,
   input  logic signed [31:0]  req_word_value,
   input  logic signed [31:0]  req_origin_x,
   input  logic signed [31:0]  req_origin_y,
   input  logic signed [31:0]  req_origin_z,
   input  logic signed [31:0]  req_dir_x,
   input  logic signed [31:0]  req_dir_y,
   input  logic signed [31:0]  req_dir_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ENTRY_W-1:0]  rsp_ellipsoid_index,
   output logic                rsp_hit,
   output logic signed [31:0]  rsp_range_along_ray,
   output logic                rsp_last,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [CFG_W-1:0]    csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   ree_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   ree_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_entry_index     (req_entry_index),
      .req_word_select     (req_word_select),
      .req_word_value      (req_word_value),
      .req_origin_x        (req_origin_x),
      .req_origin_y        (req_origin_y),
      .req_origin_z        (req_origin_z),
      .req_dir_x           (req_dir_x),
      .req_dir_y           (req_dir_y),
      .req_dir_z           (req_dir_z),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_ellipsoid_index (rsp_ellipsoid_index),
      .rsp_hit             (rsp_hit),
      .rsp_range_along_ray (rsp_range_along_ray),
      .rsp_last            (rsp_last)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending response");

   assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req_ready)
      else $error("multiply issued while accepting requests");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |-> !req_ready)
      else $error("ray ended before its last result");
`endif

endmodule

>>> tb/ray_ellipsoid_intersection_tb.sv
module ray_ellipsoid_intersection_tb;
   import ree_pkg::*;

   typedef struct {
      command_type        cmd;
      logic [ENTRY_W-1:0] entry;
      logic [WORD_W-1:0]  wsel;
      logic signed [31:0] wval;
      logic signed [31:0] org [3];
      logic signed [31:0] dir [3];
   } request_type;

   typedef struct {
      logic [ENTRY_W-1:0] idx;
      logic               hit;
      logic signed [31:0] range;
      logic               last;
   } hit_report_type;

   class intersection_scoreboard;
      logic signed [31:0] table_words [STORE_DEPTH];
      logic [CFG_W-1:0]   mahal_limit = MAX_MAHAL_RESET;
      logic [CFG_W-1:0]   range_lo    = MIN_RANGE_RESET;
      logic [CFG_W-1:0]   range_hi    = MAX_RANGE_RESET;
      logic [COUNT_W-1:0] entries_used = COUNT_RESET;
      hit_report_type     pending [$];
      int                 errors;
      int                 checked;
      int                 hits;
      int                 rays;
      int                 loads;

      function void set_csr(csr_index_type i, logic [CFG_W-1:0] v);
         case (i)
            CSR_MAX_MAHAL: mahal_limit = v;
            CSR_MIN_RANGE: range_lo = v;
            CSR_MAX_RANGE: range_hi = v;
            CSR_COUNT:     entries_used = v[COUNT_W-1:0];
            default:       entries_used = entries_used;
         endcase
      endfunction

      function longint fshift(longint x);
         return x >>> FRAC_BITS;
      endfunction

      function longint clamp32(longint x);
         if (x > 64'sh7fffffff) return 64'sh7fffffff;
         if (x < -64'sh80000000) return -64'sh80000000;
         return x;
      endfunction

      function longint dot(longint a0, a1, a2, b0, b1, b2);
         return fshift(a0 * b0) + fshift(a1 * b1) + fshift(a2 * b2);
      endfunction

      function longint quotient(longint num, longint den);
         bit                neg;
         longint unsigned   n, d, ip, r, frac, mag;
         neg = (num < 0) != (den < 0);
         n = (num < 0) ? -num : num;
         d = (den < 0) ? -den : den;
         ip = n / d;
         r = n % d;
         frac = 0;
         if (ip >= (64'd1 << (31 - FRAC_BITS)))
            return neg ? -64'sh80000000 : 64'sh7fffffff;
         for (int k = 0; k < FRAC_BITS; k++) begin
            r = r << 1;
            frac = frac << 1;
            if (r >= d) begin
               r = r - d;
               frac = frac | 1;
            end
         end
         mag = (ip << FRAC_BITS) | frac;
         return neg ? -longint'(mag) : longint'(mag);
      endfunction

      function void note_request(request_type r);
         longint o [3], d [3], mu [3], a [3][3], v [3], av [3], ad [3], ev [3], ae [3];
         longint num, den, t, m2, thr2;
         int     n, base;
         bit     hit;
         hit_report_type x;
         if (r.cmd == CMD_LOAD) begin
            loads++;
            if (r.wsel < WORD_COUNT)
               table_words[r.entry * WORDS_PER_ENTRY + r.wsel] = r.wval;
            return;
         end
         rays++;
         for (int i = 0; i < 3; i++) begin
            o[i] = longint'(r.org[i]);
            d[i] = longint'(r.dir[i]);
         end
         n = (entries_used > COUNT_MAX) ? MAX_ELLIPSOIDS : entries_used;
         thr2 = (longint'(mahal_limit) * longint'(mahal_limit)) >>> FRAC_BITS;
         for (int e = 0; e < n; e++) begin
            base = e * WORDS_PER_ENTRY;
            for (int i = 0; i < 3; i++) mu[i] = longint'(table_words[base + i]);
            a[0][0] = longint'(table_words[base + 3]);
            a[0][1] = longint'(table_words[base + 4]);
            a[0][2] = longint'(table_words[base + 5]);
            a[1][1] = longint'(table_words[base + 6]);
            a[1][2] = longint'(table_words[base + 7]);
            a[2][2] = longint'(table_words[base + 8]);
            a[1][0] = a[0][1];
            a[2][0] = a[0][2];
            a[2][1] = a[1][2];
            for (int i = 0; i < 3; i++) v[i] = clamp32(mu[i] - o[i]);
            for (int i = 0; i < 3; i++) begin
               av[i] = clamp32(dot(a[i][0], a[i][1], a[i][2], v[0], v[1], v[2]));
               ad[i] = clamp32(dot(a[i][0], a[i][1], a[i][2], d[0], d[1], d[2]));
            end
            num = dot(d[0], d[1], d[2], av[0], av[1], av[2]);
            den = dot(d[0], d[1], d[2], ad[0], ad[1], ad[2]);
            t = 0;
            hit = 0;
            if (den != 0) begin
               t = quotient(num, den);
               for (int i = 0; i < 3; i++) ev[i] = clamp32(o[i] + fshift(t * d[i]) - mu[i]);
               for (int i = 0; i < 3; i++)
                  ae[i] = clamp32(dot(a[i][0], a[i][1], a[i][2], ev[0], ev[1], ev[2]));
               m2 = dot(ev[0], ev[1], ev[2], ae[0], ae[1], ae[2]);
               hit = (m2 <= thr2) && (t >= longint'(range_lo)) && (t <= longint'(range_hi));
            end
            x.idx = e[ENTRY_W-1:0];
            x.hit = hit;
            x.range = t[31:0];
            x.last = (e + 1 == n);
            pending = {pending, x};
         end
      endfunction

      function void check_result(hit_report_type got);
         hit_report_type want;
         checked++;
         if (got.hit) hits++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result idx=%0d hit=%0d range=%0d last=%0d",
                     $time, got.idx, got.hit, got.range, got.last);
            return;
         end
         want = pending.pop_front();
         if (got.idx !== want.idx) begin
            errors++;
            $display("%0t: ellipsoid_index expected %0d actual %0d", $time, want.idx, got.idx);
         end
         if (got.hit !== want.hit) begin
            errors++;
            $display("%0t: hit expected %0d actual %0d (idx %0d)", $time, want.hit, got.hit,
                     want.idx);
         end
         if (got.range !== want.range) begin
            errors++;
            $display("%0t: range_along_ray expected %0d actual %0d (idx %0d)", $time,
                     want.range, got.range, want.idx);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last expected %0d actual %0d (idx %0d)", $time, want.last,
                     got.last, want.idx);
         end
      endfunction
   endclass

   localparam int ONE = 1 << FRAC_BITS;
   localparam int LOADED_ENTRIES = 16;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [0:0]          req_command = CMD_LOAD;
   logic [ENTRY_W-1:0]  req_entry_index = '0;
   logic [WORD_W-1:0]   req_word_select = '0;
   logic signed [31:0]  req_word_value = '0;
   logic signed [31:0]  req_origin_x = '0;
   logic signed [31:0]  req_origin_y = '0;
   logic signed [31:0]  req_origin_z = '0;
   logic signed [31:0]  req_dir_x = '0;
   logic signed [31:0]  req_dir_y = '0;
   logic signed [31:0]  req_dir_z = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ENTRY_W-1:0]  rsp_ellipsoid_index;
   logic                rsp_hit;
   logic signed [31:0]  rsp_range_along_ray;
   logic                rsp_last;
   logic                csr_write_enable = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [CFG_W-1:0]    csr_write_data = '0;

   intersection_scoreboard sb = new();
   int idle_mode;
   int hold_request;
   int stall_left;

   ray_ellipsoid_intersection dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 4000000);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic bit chance(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   always @(posedge clock) begin
      hit_report_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.idx = rsp_ellipsoid_index;
            got.hit = rsp_hit;
            got.range = rsp_range_along_ray;
            got.last = rsp_last;
            sb.check_result(got);
         end
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_mode == 2) begin
            rsp_ready <= !chance(69);
         end else if (idle_mode == 3) begin
            rsp_ready <= !chance(32);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(request_type r);
      int gap_pct;
      gap_pct = (idle_mode == 1) ? 69 : (idle_mode == 3) ? 32 : 0;
      if (chance(gap_pct)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= r.cmd;
      req_entry_index <= r.entry;
      req_word_select <= r.wsel;
      req_word_value <= r.wval;
      req_origin_x <= r.org[0];
      req_origin_y <= r.org[1];
      req_origin_z <= r.org[2];
      req_dir_x <= r.dir[0];
      req_dir_y <= r.dir[1];
      req_dir_z <= r.dir[2];
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type i, logic [CFG_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= i;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_csr(i, v);
   endtask

   task automatic configure(int mm, int lo, int hi, int cnt);
      wait_quiet();
      write_csr(CSR_MAX_MAHAL, CFG_W'(mm));
      write_csr(CSR_MIN_RANGE, CFG_W'(lo));
      write_csr(CSR_MAX_RANGE, CFG_W'(hi));
      write_csr(CSR_COUNT, CFG_W'(cnt));
   endtask

   function automatic request_type make_load(int e, int w, int val);
      request_type r;
      r.cmd = CMD_LOAD;
      r.entry = ENTRY_W'(e);
      r.wsel = WORD_W'(w);
      r.wval = val;
      for (int i = 0; i < 3; i++) begin
         r.org[i] = $urandom;
         r.dir[i] = $urandom;
      end
      return r;
   endfunction

   function automatic request_type make_ray(int o0, o1, o2, d0, d1, d2);
      request_type r;
      r.cmd = CMD_RAY;
      r.entry = ENTRY_W'($urandom);
      r.wsel = WORD_W'($urandom);
      r.wval = $urandom;
      r.org[0] = o0; r.org[1] = o1; r.org[2] = o2;
      r.dir[0] = d0; r.dir[1] = d1; r.dir[2] = d2;
      return r;
   endfunction

   function automatic int plausible_word(int w);
      if (w < 3) return int'($urandom_range(0, 40 * ONE)) - 20 * ONE;
      if (w == 3 || w == 6 || w == 8) return $urandom_range(ONE / 10, 4 * ONE);
      return int'($urandom_range(0, ONE / 2)) - ONE / 4;
   endfunction

   task automatic load_entry(int e, int w0, int w1, int w2, int w3, int w4, int w5,
                             int w6, int w7, int w8);
      int words [9];
      words = '{w0, w1, w2, w3, w4, w5, w6, w7, w8};
      for (int w = 0; w < 9; w++) send_request(make_load(e, w, words[w]));
   endtask

   task automatic random_item(int ray_pct);
      request_type r;
      int n, k, o [3], d [3];
      if (chance(ray_pct)) begin
         n = (sb.entries_used > COUNT_MAX) ? MAX_ELLIPSOIDS : sb.entries_used;
         if (chance(85) && n > 0) begin
            k = $urandom_range(0, n - 1);
            for (int i = 0; i < 3; i++) begin
               o[i] = int'($urandom_range(0, 40 * ONE)) - 20 * ONE;
               d[i] = ((sb.table_words[k * WORDS_PER_ENTRY + i] - o[i]) >>> $urandom_range(0, 4))
                      + int'($urandom_range(0, ONE / 2)) - ONE / 4;
            end
            r = make_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
         end else begin
            r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
      end else begin
         k = $urandom_range(0, 8);
         if (chance(10))
            r = make_load($urandom, $urandom_range(9, 15), $urandom);
         else if (chance(15))
            r = make_load($urandom, k, $urandom);
         else
            r = make_load($urandom, k, plausible_word(k));
      end
      send_request(r);
   endtask

   task automatic run_phase(int mode, int items);
      idle_mode = mode;
      repeat (items) random_item(60);
   endtask

   initial begin
      idle_mode = 0;
      hold_request = 0;
      stall_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_entry(0, 10 * ONE, 0, 0, ONE, 0, 0, ONE, 0, ONE);
      load_entry(1, 0, 5 * ONE, 0, ONE, 0, 0, -ONE, 0, ONE);
      load_entry(2, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0);
      load_entry(3, 32'h7fffffff, 0, 0, ONE, 0, 0, ONE, 0, ONE);
      send_request(make_load(63, 15, 32'h80000000));
      send_request(make_load(63, 0, 32'h7fffffff));
      send_request(make_ray(0, 0, 0, ONE, 0, 0));
      configure(int'(MAX_MAHAL_RESET), int'(MIN_RANGE_RESET), int'(MAX_RANGE_RESET), 4);
      send_request(make_ray(0, 0, 0, ONE, 0, 0));
      send_request(make_ray(0, 0, 0, 0, 0, 0));
      send_request(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000, 32'h80000000));
      send_request(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_request(make_ray(0, 0, 0, 256, 0, 0));
      send_request(make_ray(0, 0, 0, -256, 0, 0));
      send_request(make_ray(0, 5 * ONE, 0, 0, 0, ONE));

      wait_quiet();
      for (int e = 0; e < LOADED_ENTRIES; e++)
         for (int w = 0; w < WORDS_PER_ENTRY; w++)
            send_request(make_load(e, w, plausible_word(w)));

      configure(int'(MAX_MAHAL_RESET), 0, 120 * ONE, 3);
      run_phase(0, 40);
      configure(32'h7fffffff, 0, 32'h7fffffff, 2);
      run_phase(1, 50);
      configure(0, 32'h7fffffff, 32'h7fffffff, 4);
      run_phase(2, 50);
      configure(10 * ONE, ONE, 50 * ONE, 1);
      run_phase(3, 60);
      configure(5 * ONE, 0, 200 * ONE, 5);
      hold_request = 3000;
      run_phase(0, 40);
      configure(int'(MAX_MAHAL_RESET), 0, 120 * ONE, LOADED_ENTRIES);
      run_phase(3, 4);
      configure(2 * ONE, 0, 60 * ONE, 2);
      run_phase(2, 50);

      wait_quiet();
      repeat (200) @(posedge clock);
      $display("Covered %0d rays and %0d table loads; %0d results checked, %0d hits.",
               sb.rays, sb.loads, sb.checked, sb.hits);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
